// ===== rtl/lrrtp_pkg.sv =====
package lrrtp_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TITLE    = 2'd0,
    KIND_PASSWORD = 2'd1,
    KIND_HINT     = 2'd2,
    KIND_SUMMARY  = 2'd3
  } kind_e;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_TILE    = 3'd0;
  localparam logic [2:0] REG_RUN_MARKER     = 3'd1;
  localparam logic [2:0] REG_TEXT_MASK      = 3'd2;
  localparam logic [2:0] REG_TILES_EXPECTED = 3'd3;
  localparam logic [2:0] REG_MISC_LIMIT     = 3'd4;

  // configuration reset values
  localparam logic [7:0]  RST_TARGET_TILE    = 8'h02;
  localparam logic [7:0]  RST_RUN_MARKER     = 8'hFF;
  localparam logic [7:0]  RST_TEXT_MASK      = 8'h99;
  localparam logic [15:0] RST_TILES_EXPECTED = 16'd1024;
  localparam logic [15:0] RST_MISC_LIMIT     = 16'd1152;

  // field tags
  localparam logic [7:0] TAG_TITLE    = 8'd3;
  localparam logic [7:0] TAG_PASSWORD = 8'd6;
  localparam logic [7:0] TAG_HINT     = 8'd7;

  // layer tile total saturation point
  localparam logic [16:0] TOTAL_MAX = 17'h1FFFF;

  // warning bits
  localparam int unsigned WARN_UPPER    = 0;
  localparam int unsigned WARN_LOWER    = 1;
  localparam int unsigned WARN_MISC_SZ  = 2;
  localparam int unsigned WARN_MISC_BIG = 3;
  localparam int unsigned WARN_NO_TITLE = 4;
  localparam int unsigned WARN_NO_PASS  = 5;
  localparam int unsigned WARN_UNTERM   = 6;

  typedef struct packed {
    logic [7:0]  target_tile;
    logic [7:0]  run_marker;
    logic [7:0]  text_mask;
    logic [15:0] tiles_expected;
    logic [15:0] misc_limit;
  } cfg_t;

  // classified byte between front and back
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic [15:0] left;   // record bytes left after this one
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  text_byte;
    logic        last;
    logic [15:0] level_number;
    logic [15:0] time_limit;
    logic [15:0] chips_required;
    logic [15:0] chips_found;
    logic [6:0]  warnings;
    logic        end_error;
  } result_t;

endpackage

// ===== rtl/lrrtp_queue.sv =====
module lrrtp_queue #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/lrrtp_front.sv =====
module lrrtp_front
  import lrrtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        record_start_i,
  input  logic [15:0] record_length_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic [15:0] record_left_q, record_left_d;
  logic [15:0] len;
  logic        accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // bytes outside an open record are dropped here
  always_comb begin
    len           = record_start_i ? record_length_i : record_left_q;
    record_left_d = record_left_q;
    push_o        = 1'b0;
    entry_o.data  = data_byte_i;
    entry_o.start = record_start_i;
    entry_o.left  = len - 16'd1;
    if (accept) begin
      if (len != '0) begin
        push_o        = 1'b1;
        record_left_d = len - 16'd1;
      end else begin
        record_left_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_left_q <= '0;
    end else begin
      record_left_q <= record_left_d;
    end
  end

endmodule

// ===== rtl/lrrtp_back.sv =====
module lrrtp_back
  import lrrtp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  entry_t  entry_i,
  input  logic    room_i,
  output logic    pop_o,
  output logic [1:0] push_n_o,
  output result_t res_a_o,
  output result_t res_b_o
);

  localparam logic [3:0] PH_HDR0  = 4'd0;
  localparam logic [3:0] PH_HDR1  = 4'd1;
  localparam logic [3:0] PH_HDR2  = 4'd2;
  localparam logic [3:0] PH_HDR3  = 4'd3;
  localparam logic [3:0] PH_USIZE = 4'd4;
  localparam logic [3:0] PH_UDATA = 4'd5;
  localparam logic [3:0] PH_LSIZE = 4'd6;
  localparam logic [3:0] PH_LDATA = 4'd7;
  localparam logic [3:0] PH_MSIZE = 4'd8;
  localparam logic [3:0] PH_TAG   = 4'd9;
  localparam logic [3:0] PH_LEN   = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] layer_left_q, layer_left_d;
  logic [7:0]  word_low_q, word_low_d;
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  run_length_q, run_length_d;
  logic [16:0] tile_total_q, tile_total_d;
  logic [15:0] target_count_q, target_count_d;
  logic [15:0] hdr_q [3];
  logic [15:0] hdr_d [3];
  logic [7:0]  field_tag_q, field_tag_d;
  logic [7:0]  field_left_q, field_left_d;
  logic        nul_seen_q, nul_seen_d;
  logic [1:0]  seen_q, seen_d;
  logic [6:0]  warn_q, warn_d;

  logic [3:0]  cur_ph;
  logic [7:0]  b;
  logic [15:0] w;
  logic        rec_end;
  logic        lower;
  logic        add_en, add_match, elem_done;
  logic [7:0]  add_n;
  logic [17:0] tot_sum;
  logic [16:0] cnt_sum;
  logic        is_text;
  logic [7:0]  text_v;
  kind_e       text_kind;
  logic        has_text;
  result_t     text_res, sum_res;

  assign pop_o   = valid_i && room_i;
  assign b       = entry_i.data;
  assign rec_end = (entry_i.left == '0);

  // parser step for one byte
  always_comb begin
    // a start byte sees a cleared record
    if (entry_i.start) begin
      cur_ph         = PH_HDR0;
      layer_left_d   = '0;
      word_low_d     = '0;
      byte_pos_d     = '0;
      run_length_d   = '0;
      tile_total_d   = '0;
      target_count_d = '0;
      hdr_d[0]       = '0;
      hdr_d[1]       = '0;
      hdr_d[2]       = '0;
      field_tag_d    = '0;
      field_left_d   = '0;
      nul_seen_d     = 1'b0;
      seen_d         = '0;
      warn_d         = '0;
    end else begin
      cur_ph         = phase_q;
      layer_left_d   = layer_left_q;
      word_low_d     = word_low_q;
      byte_pos_d     = byte_pos_q;
      run_length_d   = run_length_q;
      tile_total_d   = tile_total_q;
      target_count_d = target_count_q;
      hdr_d[0]       = hdr_q[0];
      hdr_d[1]       = hdr_q[1];
      hdr_d[2]       = hdr_q[2];
      field_tag_d    = field_tag_q;
      field_left_d   = field_left_q;
      nul_seen_d     = nul_seen_q;
      seen_d         = seen_q;
      warn_d         = warn_q;
    end
    phase_d   = cur_ph;
    w         = {b, word_low_d};
    lower     = (cur_ph == PH_LDATA) || (cur_ph == PH_LSIZE);
    add_en    = 1'b0;
    add_match = 1'b0;
    add_n     = '0;
    elem_done = 1'b0;
    tot_sum   = '0;
    cnt_sum   = '0;
    is_text   = 1'b0;
    text_v    = b;
    text_kind = KIND_HINT;
    has_text  = 1'b0;

    unique case (cur_ph) inside
      PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
        if (byte_pos_d == '0) begin
          word_low_d = b;
          byte_pos_d = 2'd1;
        end else begin
          byte_pos_d = '0;
          if (cur_ph != PH_HDR3) begin
            hdr_d[cur_ph[1:0]] = w;
          end
          phase_d = cur_ph + 4'd1;
        end
      end
      PH_USIZE, PH_LSIZE: begin
        if (byte_pos_d == '0) begin
          word_low_d = b;
          byte_pos_d = 2'd1;
        end else begin
          byte_pos_d   = '0;
          layer_left_d = w;
          tile_total_d = '0;
          if (w == '0) begin
            // empty layer ends at once
            if ({1'b0, cfg_i.tiles_expected} != 17'd0) begin
              warn_d[lower ? WARN_LOWER : WARN_UPPER] = 1'b1;
            end
            phase_d = lower ? PH_MSIZE : PH_LSIZE;
          end else begin
            phase_d = lower ? PH_LDATA : PH_UDATA;
          end
        end
      end
      PH_UDATA, PH_LDATA: begin
        if (layer_left_d != '0) begin
          layer_left_d = layer_left_d - 16'd1;
        end
        case (byte_pos_d)
          2'd0: begin
            if (b == cfg_i.run_marker) begin
              byte_pos_d = 2'd1;
            end else begin
              add_en    = 1'b1;
              add_n     = 8'd1;
              add_match = (b == cfg_i.target_tile);
              elem_done = 1'b1;
            end
          end
          2'd1: begin
            run_length_d = b;
            byte_pos_d   = 2'd2;
          end
          default: begin
            byte_pos_d = '0;
            add_en     = 1'b1;
            add_n      = run_length_d;
            add_match  = (b == cfg_i.target_tile);
            elem_done  = 1'b1;
          end
        endcase
        // tile counting, both saturating
        if (add_en) begin
          tot_sum      = {1'b0, tile_total_d} + {10'd0, add_n};
          tile_total_d = (tot_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tot_sum[16:0];
          if (add_match) begin
            cnt_sum        = {1'b0, target_count_d} + {9'd0, add_n};
            target_count_d = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
          end
        end
        // layer ends after the element that uses up its count
        if (elem_done && (layer_left_d == '0)) begin
          if (tile_total_d != {1'b0, cfg_i.tiles_expected}) begin
            warn_d[lower ? WARN_LOWER : WARN_UPPER] = 1'b1;
          end
          tile_total_d = '0;
          byte_pos_d   = '0;
          phase_d      = lower ? PH_MSIZE : PH_LSIZE;
        end
      end
      PH_MSIZE: begin
        if (byte_pos_d == '0) begin
          word_low_d = b;
          byte_pos_d = 2'd1;
        end else begin
          byte_pos_d = '0;
          if (w != entry_i.left) begin
            warn_d[WARN_MISC_SZ] = 1'b1;
          end
          if (w > cfg_i.misc_limit) begin
            warn_d[WARN_MISC_BIG] = 1'b1;
          end
          phase_d = PH_TAG;
        end
      end
      PH_TAG: begin
        field_tag_d = b;
        phase_d     = PH_LEN;
      end
      PH_LEN: begin
        field_left_d = b;
        nul_seen_d   = 1'b0;
        if (field_tag_d == TAG_TITLE) begin
          seen_d[0] = 1'b1;
        end
        if (field_tag_d == TAG_PASSWORD) begin
          seen_d[1] = 1'b1;
        end
        phase_d = (b == '0) ? PH_TAG : 4'd11;
      end
      default: begin
        // field body
        is_text = (field_tag_d == TAG_TITLE) || (field_tag_d == TAG_PASSWORD) ||
                  (field_tag_d == TAG_HINT);
        if (field_left_d != '0) begin
          field_left_d = field_left_d - 8'd1;
        end
        if (is_text) begin
          text_kind = (field_tag_d == TAG_TITLE)    ? KIND_TITLE :
                      (field_tag_d == TAG_PASSWORD) ? KIND_PASSWORD : KIND_HINT;
          if ((field_tag_d == TAG_PASSWORD) && !nul_seen_d) begin
            if (b == '0) begin
              nul_seen_d = 1'b1;
            end else begin
              text_v = b ^ cfg_i.text_mask;
            end
          end
          has_text = 1'b1;
          if ((field_left_d == '0) && (b != '0)) begin
            warn_d[WARN_UNTERM] = 1'b1;
          end
        end
        if (field_left_d == '0) begin
          phase_d = PH_TAG;
        end
      end
    endcase

    // end of record checks
    if (rec_end) begin
      if (phase_d == PH_UDATA && tile_total_d != {1'b0, cfg_i.tiles_expected}) begin
        warn_d[WARN_UPPER] = 1'b1;
      end
      if (phase_d == PH_LDATA && tile_total_d != {1'b0, cfg_i.tiles_expected}) begin
        warn_d[WARN_LOWER] = 1'b1;
      end
      if (!seen_d[0]) begin
        warn_d[WARN_NO_TITLE] = 1'b1;
      end
      if (!seen_d[1]) begin
        warn_d[WARN_NO_PASS] = 1'b1;
      end
    end
  end

  // result items
  always_comb begin
    text_res                = '0;
    text_res.kind           = text_kind;
    text_res.text_byte      = text_v;
    text_res.last           = (field_left_d == '0) || rec_end;

    sum_res                 = '0;
    sum_res.kind            = KIND_SUMMARY;
    sum_res.last            = 1'b1;
    sum_res.level_number    = hdr_d[0];
    sum_res.time_limit      = hdr_d[1];
    sum_res.chips_required  = hdr_d[2];
    sum_res.chips_found     = target_count_d;
    sum_res.warnings        = warn_d;
    sum_res.end_error       = (phase_d != PH_TAG);

    if (has_text) begin
      res_a_o  = text_res;
      res_b_o  = sum_res;
      push_n_o = pop_o ? (rec_end ? 2'd2 : 2'd1) : 2'd0;
    end else begin
      res_a_o  = sum_res;
      res_b_o  = sum_res;
      push_n_o = (pop_o && rec_end) ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HDR0;
      layer_left_q   <= '0;
      word_low_q     <= '0;
      byte_pos_q     <= '0;
      run_length_q   <= '0;
      tile_total_q   <= '0;
      target_count_q <= '0;
      hdr_q[0]       <= '0;
      hdr_q[1]       <= '0;
      hdr_q[2]       <= '0;
      field_tag_q    <= '0;
      field_left_q   <= '0;
      nul_seen_q     <= 1'b0;
      seen_q         <= '0;
      warn_q         <= '0;
    end else if (pop_o) begin
      phase_q        <= phase_d;
      layer_left_q   <= layer_left_d;
      word_low_q     <= word_low_d;
      byte_pos_q     <= byte_pos_d;
      run_length_q   <= run_length_d;
      tile_total_q   <= tile_total_d;
      target_count_q <= target_count_d;
      hdr_q[0]       <= hdr_d[0];
      hdr_q[1]       <= hdr_d[1];
      hdr_q[2]       <= hdr_d[2];
      field_tag_q    <= field_tag_d;
      field_left_q   <= field_left_d;
      nul_seen_q     <= nul_seen_d;
      seen_q         <= seen_d;
      warn_q         <= warn_d;
    end
  end

endmodule

// ===== rtl/lrrtp_outbuf.sv =====
module lrrtp_outbuf
  import lrrtp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  result_t    res_a_i,
  input  result_t    res_b_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    res_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  result_t       buf_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_pop;

  // room for two items so a text byte and a summary fit together
  assign room_o      = (cnt_q <= CW'(DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign res_o       = buf_q[rd_q];
  assign do_pop      = out_valid_o && out_ready_i;
  assign cnt_d       = cnt_q + CW'(push_n_i) - CW'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + AW'(push_n_i);
      rd_q  <= rd_q + AW'(do_pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      buf_q[wr_q] <= res_a_i;
    end
    if (push_n_i == 2'd2) begin
      buf_q[wr_q + AW'(1)] <= res_b_i;
    end
  end

  // two pushes only when there was room for both
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (cnt_q <= CW'(DEPTH - 2)))
    else $error("output buffer overflow");

  // a double push is a text byte followed by the summary
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd2) |-> (res_a_i.kind != KIND_SUMMARY && res_b_i.kind == KIND_SUMMARY))
    else $error("bad result pair");

  // nothing appears at the output without a push
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && push_n_i == 2'd0) |=> !out_valid_o)
    else $error("phantom result");

endmodule

// ===== rtl/level_record_rle_tlv_parser_unit.sv =====
// Path: an accepted byte is registered in the queue, then its results in the result buffer.
// Throughput: one byte per cycle while the result buffer has room, set by the single-step
//   parser in the back end; a text byte and the summary from one byte are pushed together.
// Result buffer holds four items; the back end stalls when fewer than two are free.
// Reset: asynchronous, active low; clears the queue, buffers and parser state and
//   loads the register defaults (target 2, marker 255, mask 153, 1024, 1152).
module level_record_rle_tlv_parser_unit
  import lrrtp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        record_start_i,
  input  logic [15:0] record_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  text_byte_o,
  output logic        last_o,
  output logic [15:0] level_number_o,
  output logic [15:0] time_limit_o,
  output logic [15:0] chips_required_o,
  output logic [15:0] chips_found_o,
  output logic [6:0]  warnings_o,
  output logic        end_error_o
);

  cfg_t       cfg_q;
  logic       q_push, q_full, q_valid, q_pop;
  entry_t     q_in, q_out;
  logic       ob_room;
  logic [1:0] push_n;
  result_t    res_a, res_b, res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_tile    <= RST_TARGET_TILE;
      cfg_q.run_marker     <= RST_RUN_MARKER;
      cfg_q.text_mask      <= RST_TEXT_MASK;
      cfg_q.tiles_expected <= RST_TILES_EXPECTED;
      cfg_q.misc_limit     <= RST_MISC_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TARGET_TILE:    cfg_q.target_tile    <= cfg_data_i[7:0];
        REG_RUN_MARKER:     cfg_q.run_marker     <= cfg_data_i[7:0];
        REG_TEXT_MASK:      cfg_q.text_mask      <= cfg_data_i[7:0];
        REG_TILES_EXPECTED: cfg_q.tiles_expected <= cfg_data_i;
        REG_MISC_LIMIT:     cfg_q.misc_limit     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrrtp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .record_start_i  (record_start_i),
    .record_length_i (record_length_i),
    .queue_full_i    (q_full),
    .push_o          (q_push),
    .entry_o         (q_in)
  );

  lrrtp_queue #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_out)
  );

  lrrtp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (q_valid),
    .entry_i  (q_out),
    .room_i   (ob_room),
    .pop_o    (q_pop),
    .push_n_o (push_n),
    .res_a_o  (res_a),
    .res_b_o  (res_b)
  );

  lrrtp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .res_a_i     (res_a),
    .res_b_i     (res_b),
    .room_o      (ob_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o           = res.kind;
  assign text_byte_o      = res.text_byte;
  assign last_o           = res.last;
  assign level_number_o   = res.level_number;
  assign time_limit_o     = res.time_limit;
  assign chips_required_o = res.chips_required;
  assign chips_found_o    = res.chips_found;
  assign warnings_o       = res.warnings;
  assign end_error_o      = res.end_error;

endmodule
